@@ sv/dis_pkg.sv @@
`default_nettype none
package dis_pkg;

  localparam int TIME_W = 48;
  localparam int KEY_W = 32;
  localparam int GAP_W = 32;
  localparam int DLY_W = 10;
  localparam int DUS_W = 20;              // delay in us, up to 1023000
  localparam int MCNT_W = 5;              // remainder step counter
  localparam int SAMPLE_DEPTH_DEF = 64;
  localparam int GAP_DEPTH_DEF = 16;
  localparam int MIN_GAP_US = 5000;
  localparam int MIN_DELAY_MS = 3;
  localparam int US_PER_MS = 1000;
  localparam int ENTRY_W = TIME_W + KEY_W;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_GAP,
    ST_GREAD,
    ST_GCAND,
    ST_GSCAN,
    ST_MOD,
    ST_OUT
  } st_t;

endpackage
`default_nettype wire

@@ sv/delayed_input_sampler.sv @@
// Sequence: a sample item is written to the sample ring and returns no result. A
//   request item runs the nearest-sample scan and, when a gap is logged, the
//   median search over the gap ring and the bit-serial remainder, then loads
//   its result into the output register, waiting while that register is full.
// Throughput: one item at a time; s_tready stays low from a request until its result is loaded.
// Reset (rst, synchronous): empties both rings, clears the last request time,
//   the delay register and the output valid flag. No RAM clearing pass.
`default_nettype none
module delayed_input_sampler
  import dis_pkg::*;
#(
  parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
  parameter int GAP_DEPTH = GAP_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config
  input  wire logic        cfg_we,
  input  wire logic [9:0]  cfg_data,     // input_delay_ms
  // input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,      // [47:0] time_us, [79:48] sample_keys
  input  wire logic        s_tuser,      // cmd
  // result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [79:0] m_tdata,      // [31:0] delayed_keys, [79:32] poll_time_us
  output logic             m_tuser       // poll_valid
);

  localparam int SA_W = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int SN_W = $clog2(SAMPLE_DEPTH + 1);
  localparam int SX_W = SN_W + 1;
  localparam int GA_W = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
  localparam int GN_W = $clog2(GAP_DEPTH + 1);

  st_t state, state_next;

  // config register
  logic [DLY_W-1:0] delay_ms;

  // sample ring bookkeeping
  logic [SA_W-1:0] swptr;
  logic [SN_W-1:0] scount;

  // gap ring bookkeeping
  logic [GA_W-1:0] gwptr;
  logic [GN_W-1:0] gcount;
  logic [TIME_W-1:0] prev_req;

  // request working registers
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] target;
  logic [DUS_W-1:0] delay_us;
  logic [KEY_W-1:0] keys;
  logic poll;                  // poll time computed for this request

  // nearest-sample scan
  logic [SA_W-1:0] ra;         // ring read address being issued
  logic [SN_W-1:0] ip;         // entries issued
  logic [SN_W-1:0] cp;         // entries compared
  logic rv;                    // read data valid this cycle
  logic [TIME_W-1:0] lo_stamp, hi_stamp;
  logic [KEY_W-1:0] lo_keys, hi_keys;

  // median search
  logic [GN_W-1:0] gi, gj_is, gj_cp;
  logic [GN_W-1:0] less, le;
  logic [GAP_W-1:0] cand;
  logic [GAP_W-1:0] frame;

  // remainder unit
  logic [DUS_W-1:0] dq;
  logic [GAP_W-1:0] rem;
  logic [MCNT_W-1:0] mcnt;

  // RAM ports
  logic sram_we;
  logic [SA_W-1:0] sram_raddr;
  logic [ENTRY_W-1:0] sram_rdata;
  logic gram_we;
  logic [GA_W-1:0] gram_raddr;
  logic [GAP_W-1:0] gram_rdata;
  logic [GAP_W-1:0] gap_sat;

  dis_ram #(.WIDTH(ENTRY_W), .DEPTH(SAMPLE_DEPTH)) u_sram (
    .clk  (clk),
    .we   (sram_we),
    .waddr(swptr),
    .wdata({s_tdata[79:48], s_tdata[47:0]}),
    .raddr(sram_raddr),
    .rdata(sram_rdata)
  );

  dis_ram #(.WIDTH(GAP_W), .DEPTH(GAP_DEPTH)) u_gram (
    .clk  (clk),
    .we   (gram_we),
    .waddr(gwptr),
    .wdata(gap_sat),
    .raddr(gram_raddr),
    .rdata(gram_rdata)
  );

  // ---------------- combinational helpers ----------------
  logic in_acc, req_acc;
  logic [DLY_W-1:0] dly_clamped;
  logic [DUS_W-1:0] dus_c;
  logic [SX_W-1:0] oldest_x;
  logic [TIME_W-1:0] rd_stamp;
  logic [KEY_W-1:0] rd_keys;
  logic s_hit, s_last;
  logic [TIME_W-1:0] gap_full;
  logic push;
  logic [GN_W-1:0] kmed, less_n, le_n;
  logic g_last, g_found;
  logic [GAP_W:0] rem_sh;
  logic [TIME_W-1:0] d_lo, d_hi;
  logic out_free;

  assign in_acc = s_tvalid && s_tready;
  assign req_acc = in_acc && (s_tuser == CMD_REQUEST);
  assign dly_clamped = (delay_ms < DLY_W'(MIN_DELAY_MS)) ? DLY_W'(MIN_DELAY_MS) : delay_ms;
  assign dus_c = DUS_W'(dly_clamped * DUS_W'(US_PER_MS));

  // oldest = (wptr - n) mod depth
  assign oldest_x = SX_W'(swptr)
                  + ((scount > SN_W'(swptr)) ? SX_W'(SAMPLE_DEPTH) : SX_W'(0))
                  - SX_W'(scount);

  assign rd_stamp = sram_rdata[TIME_W-1:0];
  assign rd_keys = sram_rdata[ENTRY_W-1:TIME_W];
  assign s_hit = rv && (rd_stamp >= target);
  assign s_last = rv && (cp == scount - SN_W'(1));

  assign gap_full = now - prev_req;
  assign push = (now >= prev_req) && (gap_full >= TIME_W'(MIN_GAP_US));
  assign gap_sat = (|gap_full[TIME_W-1:GAP_W]) ? '1 : gap_full[GAP_W-1:0];

  assign kmed = gcount >> 1;
  assign less_n = less + GN_W'(gram_rdata < cand);
  assign le_n = le + GN_W'(gram_rdata <= cand);
  assign g_last = rv && (gj_cp == gcount - GN_W'(1));
  assign g_found = (less_n <= kmed) && (kmed < le_n);

  assign rem_sh = {rem, dq[DUS_W-1]};
  assign d_lo = target - lo_stamp;
  assign d_hi = hi_stamp - target;
  assign out_free = !m_tvalid || m_tready;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_acc) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scount == '0) state_next = ST_GAP;
        else if (s_hit) state_next = (cp == '0) ? ST_GAP : ST_PICK;
        else if (s_last) state_next = ST_GAP;
      end
      ST_PICK: state_next = ST_GAP;
      ST_GAP: state_next = push ? ST_GREAD : ST_OUT;
      ST_GREAD: state_next = ST_GCAND;
      ST_GCAND: state_next = ST_GSCAN;
      ST_GSCAN: begin
        if (g_last) state_next = g_found ? ST_MOD : ST_GREAD;
      end
      ST_MOD: begin
        if (mcnt == MCNT_W'(DUS_W - 1)) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    s_tready = (state == ST_IDLE);
    sram_we = (state == ST_IDLE) && s_tvalid && (s_tuser == CMD_SAMPLE);
    sram_raddr = ra;
    gram_we = (state == ST_GAP) && push;
    gram_raddr = (state == ST_GREAD) ? gi[GA_W-1:0] : gj_is[GA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config, ring pointers, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms <= '0;
      swptr <= '0;
      scount <= '0;
      gwptr <= '0;
      gcount <= '0;
      prev_req <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) delay_ms <= cfg_data;
      if (sram_we) begin
        swptr <= (swptr == SA_W'(SAMPLE_DEPTH - 1)) ? '0 : swptr + SA_W'(1);
        if (scount != SN_W'(SAMPLE_DEPTH)) scount <= scount + SN_W'(1);
      end
      if (gram_we) begin
        gwptr <= (gwptr == GA_W'(GAP_DEPTH - 1)) ? '0 : gwptr + GA_W'(1);
        if (gcount != GN_W'(GAP_DEPTH)) gcount <= gcount + GN_W'(1);
        prev_req <= now;
      end
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rv <= 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_acc) begin
          now <= s_tdata[47:0];
          delay_us <= dus_c;
          target <= (s_tdata[47:0] > TIME_W'(dus_c)) ? s_tdata[47:0] - TIME_W'(dus_c) : '0;
          ra <= oldest_x[SA_W-1:0];
          ip <= '0;
          cp <= '0;
          keys <= '0;
          poll <= 1'b0;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, compare the returning entry
        if (ip < scount) begin
          ra <= (ra == SA_W'(SAMPLE_DEPTH - 1)) ? '0 : ra + SA_W'(1);
          ip <= ip + SN_W'(1);
          rv <= !(s_hit || s_last);
        end
        if (rv) begin
          cp <= cp + SN_W'(1);
          if (s_hit) begin
            hi_stamp <= rd_stamp;
            hi_keys <= rd_keys;
            if (cp == '0) keys <= rd_keys;
          end else begin
            lo_stamp <= rd_stamp;
            lo_keys <= rd_keys;
            if (s_last) keys <= rd_keys;
          end
        end
      end
      ST_PICK: begin
        keys <= (d_lo > d_hi) ? hi_keys : lo_keys;   // tie goes to earlier
      end
      ST_GAP: begin
        gi <= '0;
      end
      ST_GREAD: begin
        gj_is <= '0;
        gj_cp <= '0;
        less <= '0;
        le <= '0;
      end
      ST_GCAND: begin
        cand <= gram_rdata;
        gj_is <= GN_W'(1);
        rv <= 1'b1;
      end
      ST_GSCAN: begin
        if (gj_is < gcount && !g_last) begin
          gj_is <= gj_is + GN_W'(1);
          rv <= 1'b1;
        end
        if (rv) begin
          gj_cp <= gj_cp + GN_W'(1);
          less <= less_n;
          le <= le_n;
          if (g_last) begin
            gi <= gi + GN_W'(1);
            frame <= cand;
            rem <= '0;
            dq <= delay_us;
            mcnt <= '0;
          end
        end
      end
      ST_MOD: begin
        // restoring remainder, one dividend bit a cycle
        rem <= (rem_sh >= {1'b0, frame}) ? GAP_W'(rem_sh - {1'b0, frame}) : rem_sh[GAP_W-1:0];
        dq <= dq << 1;
        mcnt <= mcnt + MCNT_W'(1);
        poll <= 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata[31:0] <= keys;
          m_tdata[79:32] <= poll ? now + TIME_W'(rem) : '0;
          m_tuser <= poll;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/dis_ram.sv @@
`default_nettype none
module dis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/dis_checker.sv @@
`default_nettype none
module dis_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_nopoll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[79:32] == 48'd0)
    else $error("poll time set without poll flag");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("took an item during a request");

endmodule

bind delayed_input_sampler dis_checker u_dis_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
`default_nettype wire
